// ===== design/assert_macros.svh =====
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds on every clock edge out of reset
`define PTD_ASSERT_ALWAYS(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("invariant violated");

// consequent holds in the cycle after the antecedent
`define PTD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sequence violated");

`endif

// ===== design/ptd_pkg.sv =====
`timescale 1ns / 1ps

package ptd_pkg;

    // sizing
    localparam int MAX_TASKS   = 8;
    localparam int STACK_DEPTH = 16;
    localparam int COUNT_WIDTH = 16;

    localparam int TASK_IDX_W = $clog2(MAX_TASKS);
    localparam int TASK_CNT_W = $clog2(MAX_TASKS + 1);
    localparam int STK_IDX_W  = $clog2(STACK_DEPTH);
    localparam int STK_FILL_W = $clog2(STACK_DEPTH + 1);

    // fixed field widths
    localparam int PERIOD_W   = 16;
    localparam int LATE_W     = 16;
    localparam int OFFSET_W   = 16;
    localparam int IDX_OUT_W  = 3;
    localparam int DUR_W      = 16;
    localparam int CAP_W      = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // countdown difference, signed, wide enough for either operand
    localparam int DIFF_W = ((COUNT_WIDTH > OFFSET_W) ? COUNT_WIDTH : OFFSET_W) + 1;

    // divider
    localparam int DIV_W     = 16;
    localparam int DIV_CNT_W = $clog2(DIV_W);

    localparam logic [OFFSET_W-1:0] OFFSET_MAX = '1;
    localparam logic [DUR_W-1:0]    DUR_RESET  = DUR_W'(1000);
    localparam logic [CAP_W-1:0]    CAP_RESET  = CAP_W'(8);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SLOT_DURATION = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_TASK_CAPACITY = CFG_IDX_W'(1);

    // command codes
    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    typedef struct packed {
        logic                command;
        logic [PERIOD_W-1:0] task_period;
        logic [LATE_W-1:0]   late_ms;
    } item_t;

    typedef struct packed {
        logic                 add_accepted;
        logic                 dispatch_valid;
        logic [IDX_OUT_W-1:0] dispatch_task;
        logic                 background_valid;
        logic [IDX_OUT_W-1:0] background_task;
        logic                 stack_overflow;
        logic [OFFSET_W-1:0]  offset_used;
    } result_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } div_req_t;

endpackage

// ===== design/ptd_ram.sv =====
`timescale 1ns / 1ps

module ptd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/ptd_div.sv =====
`timescale 1ns / 1ps

// restoring divider, one quotient bit per cycle
module ptd_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  ptd_pkg::div_req_t           req,
    output logic                        done,
    output logic [ptd_pkg::DIV_W-1:0]   quotient
);

    localparam int W  = ptd_pkg::DIV_W;
    localparam int CW = ptd_pkg::DIV_CNT_W;

    logic          run_reg, run_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [W-1:0]  acc_reg, acc_next;
    logic [W-1:0]  rem_reg, rem_next;
    logic [W-1:0]  dsr_reg, dsr_next;

    logic [W:0] trial;
    logic [W:0] diff;
    logic       ge;

    always_comb
    begin
        trial     = {rem_reg, acc_reg[W-1]};
        diff      = trial - {1'b0, dsr_reg};
        ge        = (trial >= {1'b0, dsr_reg});
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (req.start)
        begin
            run_next = 1'b1;
            cnt_next = CW'(W - 1);
            acc_next = req.dividend;
            rem_next = '0;
            dsr_next = req.divisor;
        end
        else if (run_reg)
        begin
            acc_next = {acc_reg[W-2:0], ge};
            rem_next = ge ? diff[W-1:0] : trial[W-1:0];
            if (cnt_reg == '0)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = acc_reg;

endmodule

// ===== design/periodic_task_tick_dispatcher.sv =====
`timescale 1ns / 1ps
// add word: S_ADD stores the task if there is room, then done rises as the block returns to idle
// tick word: S_DIV and S_DIVW (divider start, 16 steps, done) when lateness is pending,
// then S_POP, S_POPW, S_TRD/S_TUPD for each task but the last (n >= 2), and S_FIN
// worst case per tick set by the 16-step divider and the S_TRD/S_TUPD task walk
// result is shown for one cycle on done, the receiver cannot stall it
// async active-low reset clears tasks, stack fill, pending flag; offset resets to 1

`include "assert_macros.svh"

module periodic_task_tick_dispatcher (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  ptd_pkg::item_t                    item,
    input  logic                              cfg_write,
    input  logic [ptd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ptd_pkg::CFG_DATA_W-1:0]    cfg_data,
    output logic                              done,
    output ptd_pkg::result_t                  result
);

    localparam int TIW = ptd_pkg::TASK_IDX_W;
    localparam int TCW = ptd_pkg::TASK_CNT_W;
    localparam int SIW = ptd_pkg::STK_IDX_W;
    localparam int SFW = ptd_pkg::STK_FILL_W;
    localparam int CNW = ptd_pkg::COUNT_WIDTH;
    localparam int DFW = ptd_pkg::DIFF_W;
    localparam int OFW = ptd_pkg::OFFSET_W;
    localparam int IOW = ptd_pkg::IDX_OUT_W;

    // sequencer states
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_ADD  = 4'd1;
    localparam logic [3:0] S_DIV  = 4'd2;
    localparam logic [3:0] S_DIVW = 4'd3;
    localparam logic [3:0] S_POP  = 4'd4;
    localparam logic [3:0] S_POPW = 4'd5;
    localparam logic [3:0] S_TRD  = 4'd6;
    localparam logic [3:0] S_TUPD = 4'd7;
    localparam logic [3:0] S_FIN  = 4'd8;

    logic [3:0] state_reg, state_next;

    // configuration
    logic [ptd_pkg::DUR_W-1:0] slot_duration_reg;
    logic [ptd_pkg::CAP_W-1:0] task_capacity_reg;

    // control state
    logic [TCW-1:0] task_count_reg, task_count_next;
    logic [SFW-1:0] stack_fill_reg, stack_fill_next;
    logic [OFW-1:0] tick_offset_reg, tick_offset_next;
    logic           pending_reg, pending_next;
    logic           done_reg, done_next;

    // per-word working registers
    ptd_pkg::item_t   item_reg;
    ptd_pkg::result_t result_reg, result_next;
    logic [TIW-1:0]   idx_reg, idx_next;
    logic             dv_reg, dv_next;
    logic [IOW-1:0]   dt_reg, dt_next;
    logic             ovf_reg, ovf_next;

    // task table: period in the upper half, countdown in the lower half
    logic             tbl_wr_en;
    logic [TIW-1:0]   tbl_wr_addr;
    logic [2*CNW-1:0] tbl_wr_data;
    logic [TIW-1:0]   tbl_rd_addr;
    logic [2*CNW-1:0] tbl_rd_data;

    // ready stack, lifo
    logic           stk_wr_en;
    logic [SIW-1:0] stk_wr_addr;
    logic [TIW-1:0] stk_wr_data;
    logic [SIW-1:0] stk_rd_addr;
    logic [TIW-1:0] stk_rd_data;

    ptd_pkg::div_req_t div_req;
    logic              div_done;
    logic [ptd_pkg::DIV_W-1:0] div_quot;

    // countdown update arithmetic
    logic [CNW-1:0]        cd_cur;
    logic [CNW-1:0]        per_cur;
    logic signed [DFW-1:0] cd_diff;
    logic                  cd_push;
    logic                  cd_reload;
    logic                  add_ok;
    logic                  accept;

    ptd_ram #(
        .WIDTH (2 * CNW),
        .DEPTH (ptd_pkg::MAX_TASKS)
    ) u_task_ram (
        .clk     (clk),
        .wr_en   (tbl_wr_en),
        .wr_addr (tbl_wr_addr),
        .wr_data (tbl_wr_data),
        .rd_addr (tbl_rd_addr),
        .rd_data (tbl_rd_data)
    );

    ptd_ram #(
        .WIDTH (TIW),
        .DEPTH (ptd_pkg::STACK_DEPTH)
    ) u_stack_ram (
        .clk     (clk),
        .wr_en   (stk_wr_en),
        .wr_addr (stk_wr_addr),
        .wr_data (stk_wr_data),
        .rd_addr (stk_rd_addr),
        .rd_data (stk_rd_data)
    );

    ptd_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign accept = start && (state_reg == S_IDLE);
    assign busy   = (state_reg != S_IDLE);

    // room for one more task: below both the written capacity and the table size
    assign add_ok = (32'(task_count_reg) < 32'(task_capacity_reg))
                 && (32'(task_count_reg) < ptd_pkg::MAX_TASKS);

    always_comb
    begin
        cd_cur    = tbl_rd_data[CNW-1:0];
        per_cur   = tbl_rd_data[2*CNW-1:CNW];
        cd_diff   = $signed(DFW'(cd_cur) - DFW'(tick_offset_reg));
        cd_push   = (cd_diff <= $signed(DFW'(1)));
        cd_reload = (cd_diff <= $signed(DFW'(0)));
    end

    always_comb
    begin
        state_next       = state_reg;
        task_count_next  = task_count_reg;
        stack_fill_next  = stack_fill_reg;
        tick_offset_next = tick_offset_reg;
        pending_next     = pending_reg;
        done_next        = 1'b0;
        result_next      = result_reg;
        idx_next         = idx_reg;
        dv_next          = dv_reg;
        dt_next          = dt_reg;
        ovf_next         = ovf_reg;

        tbl_wr_en   = 1'b0;
        tbl_wr_addr = idx_reg;
        tbl_wr_data = {per_cur, cd_cur};
        tbl_rd_addr = idx_reg;
        stk_wr_en   = 1'b0;
        stk_wr_addr = SIW'(stack_fill_reg);
        stk_wr_data = idx_reg;
        stk_rd_addr = SIW'(stack_fill_reg - 1'b1);

        div_req.start    = 1'b0;
        div_req.dividend = item_reg.late_ms;
        div_req.divisor  = slot_duration_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    dv_next  = 1'b0;
                    dt_next  = '0;
                    ovf_next = 1'b0;
                    idx_next = '0;
                    if (item.command == ptd_pkg::CMD_ADD)
                    begin
                        state_next = S_ADD;
                    end
                    else if (pending_reg)
                    begin
                        state_next = S_DIV;
                    end
                    else
                    begin
                        state_next = S_POP;
                    end
                end
            end

            S_ADD:
            begin
                // new slot starts its countdown at the full period
                tbl_wr_addr = TIW'(task_count_reg);
                tbl_wr_data = {CNW'(item_reg.task_period), CNW'(item_reg.task_period)};
                if (add_ok)
                begin
                    tbl_wr_en       = 1'b1;
                    task_count_next = task_count_reg + 1'b1;
                end
                result_next              = '0;
                result_next.add_accepted = add_ok;
                result_next.offset_used  = tick_offset_reg;
                done_next                = 1'b1;
                state_next               = S_IDLE;
            end

            S_DIV:
            begin
                div_req.start = 1'b1;
                state_next    = S_DIVW;
            end

            S_DIVW:
            begin
                if (div_done)
                begin
                    // zero slot length: on time gives 1, any lateness saturates
                    if (slot_duration_reg == '0)
                    begin
                        tick_offset_next = (item_reg.late_ms == '0) ? OFW'(1)
                                                                    : ptd_pkg::OFFSET_MAX;
                    end
                    else if (OFW'(div_quot) == ptd_pkg::OFFSET_MAX)
                    begin
                        tick_offset_next = ptd_pkg::OFFSET_MAX;
                    end
                    else
                    begin
                        tick_offset_next = OFW'(div_quot) + 1'b1;
                    end
                    state_next = S_POP;
                end
            end

            S_POP:
            begin
                // read the top entry now, pushes only come after it is captured
                if (stack_fill_reg != '0)
                begin
                    stack_fill_next = stack_fill_reg - 1'b1;
                    dv_next         = 1'b1;
                end
                state_next = S_POPW;
            end

            S_POPW:
            begin
                if (dv_reg)
                begin
                    dt_next = IOW'(stk_rd_data);
                end
                idx_next = '0;
                if (32'(task_count_reg) >= 2)
                begin
                    state_next = S_TRD;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end

            S_TRD:
            begin
                state_next = S_TUPD;
            end

            S_TUPD:
            begin
                tbl_wr_en   = 1'b1;
                tbl_wr_data = {per_cur, cd_reload ? per_cur : CNW'(cd_diff)};
                if (cd_push)
                begin
                    if (32'(stack_fill_reg) < ptd_pkg::STACK_DEPTH)
                    begin
                        stk_wr_en       = 1'b1;
                        stack_fill_next = stack_fill_reg + 1'b1;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                end
                // last task is the background one and is not counted down
                if (32'(idx_reg) + 2 < 32'(task_count_reg))
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_TRD;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end

            S_FIN:
            begin
                result_next                = '0;
                result_next.dispatch_valid = dv_reg;
                result_next.dispatch_task  = dt_reg;
                result_next.stack_overflow = ovf_reg;
                result_next.offset_used    = tick_offset_reg;
                if (stack_fill_reg == '0)
                begin
                    if (task_count_reg != '0)
                    begin
                        result_next.background_valid = 1'b1;
                        result_next.background_task  = IOW'(task_count_reg - 1'b1);
                    end
                    pending_next = 1'b0;
                end
                else
                begin
                    pending_next = 1'b1;
                end
                done_next  = 1'b1;
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            slot_duration_reg <= ptd_pkg::DUR_RESET;
            task_capacity_reg <= ptd_pkg::CAP_RESET;
            task_count_reg    <= '0;
            stack_fill_reg    <= '0;
            tick_offset_reg   <= OFW'(1);
            pending_reg       <= 1'b0;
            done_reg          <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            task_count_reg  <= task_count_next;
            stack_fill_reg  <= stack_fill_next;
            tick_offset_reg <= tick_offset_next;
            pending_reg     <= pending_next;
            done_reg        <= done_next;
            if (cfg_write)
            begin
                if (cfg_index == ptd_pkg::REG_SLOT_DURATION)
                begin
                    slot_duration_reg <= ptd_pkg::DUR_W'(cfg_data);
                end
                else if (cfg_index == ptd_pkg::REG_TASK_CAPACITY)
                begin
                    task_capacity_reg <= ptd_pkg::CAP_W'(cfg_data);
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item;
        end
        result_reg <= result_next;
        idx_reg    <= idx_next;
        dv_reg     <= dv_next;
        dt_reg     <= dt_next;
        ovf_reg    <= ovf_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    // checks
    `PTD_ASSERT_ALWAYS(a_fill_bound, 32'(stack_fill_reg) <= ptd_pkg::STACK_DEPTH)
    `PTD_ASSERT_ALWAYS(a_count_bound, 32'(task_count_reg) <= ptd_pkg::MAX_TASKS)
    `PTD_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
    `PTD_ASSERT_NEXT(a_done_pulse, done_reg, !done_reg)
    `PTD_ASSERT_ALWAYS(a_add_clean, !(done_reg && result_reg.add_accepted) ||
        (!result_reg.dispatch_valid && !result_reg.background_valid &&
         !result_reg.stack_overflow))

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;

    // clock, reset and block ports
    logic    clk;
    logic    rst_n;
    logic    start;
    logic    busy;
    ptd_pkg::item_t   item;
    logic    cfg_write;
    logic [ptd_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [ptd_pkg::CFG_DATA_W-1:0] cfg_data;
    logic    done;
    ptd_pkg::result_t result;

    periodic_task_tick_dispatcher u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .done      (done),
        .result    (result)
    );

    // 20 ns period
    always #10 clk = ~clk;

    // scheduler shadow state, kept in step with every accepted word
    logic [ptd_pkg::PERIOD_W-1:0]   sched_period [ptd_pkg::MAX_TASKS];
    int                             sched_countdown [ptd_pkg::MAX_TASKS];
    int unsigned                    sched_tasks;
    logic [ptd_pkg::TASK_IDX_W-1:0] sched_ready [ptd_pkg::STACK_DEPTH];
    int unsigned                    sched_fill;
    logic [ptd_pkg::OFFSET_W-1:0]   sched_offset;
    logic                           sched_late_pending;
    logic [ptd_pkg::DUR_W-1:0]      sched_slot_ms;
    logic [ptd_pkg::CAP_W-1:0]      sched_capacity;

    // outcomes still owed by the block, oldest first
    ptd_pkg::result_t pending_outcomes [$];
    int unsigned mismatch_count;
    int unsigned words_seen;
    int unsigned sender_idle_pct;

    // work out the outcome of one word and move the shadow state on
    function automatic ptd_pkg::result_t dispatch_outcome(ptd_pkg::item_t w);
        ptd_pkg::result_t r;
        int unsigned      eff_cap;
        int unsigned      quot;
        r = '0;
        if (w.command == ptd_pkg::CMD_ADD)
        begin
            // capacity register above the table size is clamped
            eff_cap = (sched_capacity > ptd_pkg::MAX_TASKS) ? ptd_pkg::MAX_TASKS
                                                             : sched_capacity;
            if (sched_tasks < eff_cap)
            begin
                sched_period[sched_tasks]    = w.task_period;
                sched_countdown[sched_tasks] = int'(w.task_period);
                sched_tasks++;
                r.add_accepted = 1'b1;
            end
        end
        else
        begin
            // lateness left over from a busy slot sets the decrement
            if (sched_late_pending)
            begin
                if (sched_slot_ms == '0)
                begin
                    sched_offset = (w.late_ms == '0) ? ptd_pkg::OFFSET_W'(1)
                                                     : ptd_pkg::OFFSET_MAX;
                end
                else
                begin
                    quot = int'(w.late_ms) / int'(sched_slot_ms);
                    sched_offset = (quot >= int'(ptd_pkg::OFFSET_MAX))
                                 ? ptd_pkg::OFFSET_MAX
                                 : ptd_pkg::OFFSET_W'(quot + 1);
                end
            end
            // pop before the walk, so a task pushed now waits a tick
            if (sched_fill > 0)
            begin
                sched_fill--;
                r.dispatch_valid = 1'b1;
                r.dispatch_task  = ptd_pkg::IDX_OUT_W'(sched_ready[sched_fill]);
            end
            // the last task is the background one and never counts down
            for (int i = 0; i + 1 < sched_tasks; i++)
            begin
                sched_countdown[i] -= int'(sched_offset);
                if (sched_countdown[i] <= 1)
                begin
                    if (sched_fill < ptd_pkg::STACK_DEPTH)
                    begin
                        sched_ready[sched_fill] = ptd_pkg::TASK_IDX_W'(i);
                        sched_fill++;
                    end
                    else
                    begin
                        r.stack_overflow = 1'b1;
                    end
                end
                if (sched_countdown[i] <= 0)
                    sched_countdown[i] = int'(sched_period[i]);
            end
            if (sched_fill == 0)
            begin
                if (sched_tasks > 0)
                begin
                    r.background_valid = 1'b1;
                    r.background_task  = ptd_pkg::IDX_OUT_W'(sched_tasks - 1);
                end
                sched_late_pending = 1'b0;
            end
            else
            begin
                sched_late_pending = 1'b1;
            end
        end
        r.offset_used = sched_offset;
        return r;
    endfunction

    // compare every strobed result with the oldest outstanding outcome
    always @(posedge clk)
    begin
        ptd_pkg::result_t want;
        if (rst_n && done)
        begin
            words_seen++;
            if (pending_outcomes.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("result %0d arrived with nothing outstanding: %h",
                             words_seen, result);
            end
            else
            begin
                want = pending_outcomes.pop_front();
                if (result.add_accepted     !== want.add_accepted     ||
                    result.dispatch_valid   !== want.dispatch_valid   ||
                    result.dispatch_task    !== want.dispatch_task    ||
                    result.background_valid !== want.background_valid ||
                    result.background_task  !== want.background_task  ||
                    result.stack_overflow   !== want.stack_overflow   ||
                    result.offset_used      !== want.offset_used)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"result %0d: expected acc=%b dv=%b dt=%0d bv=%b bt=%0d ",
                                  "ovf=%b off=%0d, got acc=%b dv=%b dt=%0d bv=%b bt=%0d ",
                                  "ovf=%b off=%0d"}, words_seen,
                                 want.add_accepted, want.dispatch_valid,
                                 want.dispatch_task, want.background_valid,
                                 want.background_task, want.stack_overflow,
                                 want.offset_used,
                                 result.add_accepted, result.dispatch_valid,
                                 result.dispatch_task, result.background_valid,
                                 result.background_task, result.stack_overflow,
                                 result.offset_used);
                end
            end
        end
    end

    // hand one word over, after an optional gap with start low
    task automatic send_word(input ptd_pkg::item_t w, input int unsigned gap);
        @(negedge clk);
        if (gap > 0)
        begin
            start = 1'b0;
            repeat (gap) @(negedge clk);
        end
        start = 1'b1;
        item  = w;
        // accepted on the first rising edge that sees busy low
        forever
        begin
            @(posedge clk);
            if (!busy)
                break;
        end
        pending_outcomes.push_back(dispatch_outcome(w));
    endtask

    // stop sending, let every outcome arrive, then cover the longest tick
    task automatic wait_quiet();
        @(negedge clk);
        start = 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (48) @(posedge clk);
    endtask

    // register write, only ever issued with the block quiet
    task automatic write_reg(input logic [ptd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [ptd_pkg::CFG_DATA_W-1:0] value);
        @(negedge clk);
        start     = 1'b0;
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(negedge clk);
        cfg_write = 1'b0;
        if (idx == ptd_pkg::REG_SLOT_DURATION)
            sched_slot_ms = value;
        else if (idx == ptd_pkg::REG_TASK_CAPACITY)
            sched_capacity = value[ptd_pkg::CAP_W-1:0];
    endtask

    // sender gap: mostly per-cycle idling, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned gap;
        gap = 0;
        if (sender_idle_pct > 0)
        begin
            while ($urandom_range(99) < sender_idle_pct && gap < 60)
                gap++;
            if ($urandom_range(9) == 0)
                gap += $urandom_range(0, 40);
        end
        return gap;
    endfunction

    function automatic ptd_pkg::item_t make_add(input logic [ptd_pkg::PERIOD_W-1:0] period);
        ptd_pkg::item_t w;
        w.command     = ptd_pkg::CMD_ADD;
        w.task_period = period;
        w.late_ms     = ptd_pkg::LATE_W'($urandom);
        return w;
    endfunction

    function automatic ptd_pkg::item_t make_tick(input logic [ptd_pkg::LATE_W-1:0] late);
        ptd_pkg::item_t w;
        w.command     = ptd_pkg::CMD_TICK;
        w.task_period = ptd_pkg::PERIOD_W'($urandom);
        w.late_ms     = late;
        return w;
    endfunction

    // ticks with nothing registered: no dispatch, no background
    task automatic test_empty_schedule();
        send_word(make_tick('0), 0);
        send_word(make_tick(ptd_pkg::OFFSET_MAX), 0);
        send_word(make_tick(ptd_pkg::LATE_W'(1234)), 2);
    endtask

    // adds against zero, small, lowered and oversized capacity
    task automatic test_capacity();
        wait_quiet();
        write_reg(ptd_pkg::REG_TASK_CAPACITY, ptd_pkg::CFG_DATA_W'(0));
        send_word(make_add(ptd_pkg::PERIOD_W'(5)), 0);
        wait_quiet();
        write_reg(ptd_pkg::REG_TASK_CAPACITY, ptd_pkg::CFG_DATA_W'(2));
        send_word(make_add('0), 0);
        send_word(make_add('1), 0);
        send_word(make_add(ptd_pkg::PERIOD_W'(7)), 0);
        wait_quiet();
        // lowered below the number already held
        write_reg(ptd_pkg::REG_TASK_CAPACITY, ptd_pkg::CFG_DATA_W'(1));
        send_word(make_add(ptd_pkg::PERIOD_W'(3)), 0);
        wait_quiet();
        // above the table size, clamped
        write_reg(ptd_pkg::REG_TASK_CAPACITY, ptd_pkg::CFG_DATA_W'(15));
        send_word(make_add(ptd_pkg::PERIOD_W'(1)), 0);
    endtask

    // lateness division: default slot, longest, shortest and zero slot
    task automatic test_lateness();
        send_word(make_tick('0), 0);
        send_word(make_tick(ptd_pkg::OFFSET_MAX), 0);
        wait_quiet();
        write_reg(ptd_pkg::REG_SLOT_DURATION, ptd_pkg::CFG_DATA_W'(65535));
        send_word(make_tick(ptd_pkg::OFFSET_MAX), 0);
        wait_quiet();
        write_reg(ptd_pkg::REG_SLOT_DURATION, ptd_pkg::CFG_DATA_W'(1));
        send_word(make_tick(ptd_pkg::OFFSET_MAX), 0);
        send_word(make_tick('0), 0);
        wait_quiet();
        write_reg(ptd_pkg::REG_SLOT_DURATION, ptd_pkg::CFG_DATA_W'(0));
        send_word(make_tick('0), 0);
        send_word(make_tick(ptd_pkg::LATE_W'(9)), 0);
    endtask

    // zero slot with lateness saturates the offset, so both walking
    // tasks push every tick and the stack fills by one per tick
    task automatic test_stack_overflow();
        repeat (20)
            send_word(make_tick(ptd_pkg::LATE_W'($urandom_range(1, 65535))), 0);
    endtask

    // one random phase at a given slot length, capacity and sender idling
    task automatic test_random_phase(input logic [ptd_pkg::CFG_DATA_W-1:0] slot_ms,
                                     input logic [ptd_pkg::CFG_DATA_W-1:0] capacity,
                                     input int unsigned idle_pct,
                                     input int unsigned words);
        ptd_pkg::item_t w;
        int unsigned    pick;
        wait_quiet();
        write_reg(ptd_pkg::REG_SLOT_DURATION, slot_ms);
        write_reg(ptd_pkg::REG_TASK_CAPACITY, capacity);
        sender_idle_pct = idle_pct;
        for (int n = 0; n < words; n++)
        begin
            w.command = ($urandom_range(99) < 12) ? ptd_pkg::CMD_ADD : ptd_pkg::CMD_TICK;
            // periods mostly short so tasks actually come due
            pick = $urandom_range(9);
            if (pick <= 5)
                w.task_period = ptd_pkg::PERIOD_W'($urandom_range(0, 12));
            else if (pick <= 7)
                w.task_period = ptd_pkg::PERIOD_W'($urandom_range(0, 300));
            else if (pick == 8)
                w.task_period = ptd_pkg::PERIOD_W'($urandom);
            else
                w.task_period = $urandom_range(1) ? '1 : '0;
            // lateness mostly none or a few slots, sometimes anything
            pick = $urandom_range(9);
            if (pick <= 4)
                w.late_ms = '0;
            else if (pick <= 7)
                w.late_ms = ptd_pkg::LATE_W'($urandom_range(0, 4000));
            else
                w.late_ms = ptd_pkg::LATE_W'($urandom);
            send_word(w, pick_gap());
            // now and then hold off until the block has caught up
            if ($urandom_range(39) == 0)
                wait_quiet();
        end
    endtask

    initial
    begin
        clk       = 1'b0;
        rst_n     = 1'b0;
        start     = 1'b0;
        item      = '0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;

        // shadow state matches the block after reset
        sched_tasks        = 0;
        sched_fill         = 0;
        sched_offset       = ptd_pkg::OFFSET_W'(1);
        sched_late_pending = 1'b0;
        sched_slot_ms      = ptd_pkg::DUR_RESET;
        sched_capacity     = ptd_pkg::CAP_RESET;
        for (int i = 0; i < ptd_pkg::MAX_TASKS; i++)
        begin
            sched_period[i]    = '0;
            sched_countdown[i] = 0;
        end
        for (int i = 0; i < ptd_pkg::STACK_DEPTH; i++)
            sched_ready[i] = '0;
        mismatch_count  = 0;
        words_seen      = 0;
        sender_idle_pct = 0;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_empty_schedule();
        test_capacity();
        test_lateness();
        test_stack_overflow();
        test_random_phase(ptd_pkg::CFG_DATA_W'(1000), ptd_pkg::CFG_DATA_W'(4), 0, 380);
        test_random_phase(ptd_pkg::CFG_DATA_W'(65535), ptd_pkg::CFG_DATA_W'(6), 68, 380);
        test_random_phase(ptd_pkg::CFG_DATA_W'(1), ptd_pkg::CFG_DATA_W'(8), 26, 380);
        test_random_phase(ptd_pkg::CFG_DATA_W'($urandom_range(1, 65535)),
                          ptd_pkg::CFG_DATA_W'(0), 68, 380);

        wait_quiet();
        if (mismatch_count == 0 && pending_outcomes.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // run limit, far beyond the slowest correct run
    initial
    begin
        #20000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+design
design/ptd_pkg.sv
design/ptd_ram.sv
design/ptd_div.sv
design/periodic_task_tick_dispatcher.sv
dv/tb.sv
